// ===== sv/boxf_pkg.sv =====
// Shared constants, types and the divide-by-nine helper for the 3x3 RGB box filter.
// No dependencies; imported by the top level and the port checker.
`default_nettype none

package boxf_pkg;

  localparam int MAX_WIDTH  = 2048;                // deepest supported line
  localparam int COL_W      = $clog2(MAX_WIDTH);   // column counter / line index width
  localparam int ROW_W      = 12;                  // row counter width
  localparam int DIM_W      = 12;                  // geometry register width
  localparam int CHAN_W     = 8;
  localparam int PIX_W      = 3 * CHAN_W;
  localparam int SUM_W      = 12;                  // nine 8-bit samples
  localparam int MAX_HEIGHT = 4095;
  localparam int MIN_DIM    = 3;

  // floor(s / 9) == (s * 7282) >> 16 for every s below 2**15
  localparam int RECIP_W     = 13;
  localparam int RECIP_SHIFT = 16;
  localparam logic [RECIP_W-1:0] RECIP_NINE = RECIP_W'(7282);

  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  typedef enum logic {
    REG_IMAGE_WIDTH  = 1'b0,
    REG_IMAGE_HEIGHT = 1'b1
  } reg_idx_t;

  typedef logic [PIX_W-1:0] pixel_t;   // {red, green, blue}

  function automatic logic [CHAN_W-1:0] div_nine(input logic [SUM_W-1:0] s);
    logic [SUM_W+RECIP_W-1:0] prod;
    prod = SUM_W'(s) * RECIP_NINE;
    return prod[RECIP_SHIFT +: CHAN_W];
  endfunction

endpackage

`default_nettype wire

// ===== sv/box_filter_3x3_rgb_top.sv =====
// Top level of the streaming 3x3 RGB box (mean) filter: line memory, window,
// raster counters, APB register file. Depends on boxf_pkg.
`default_nettype none

// Streaming 3x3 mean filter for RGB pixels in raster order. Accepts one pixel
// per clock and, when the pipeline is not stalled by the result side, keeps
// that rate indefinitely; a pixel's result (if it produces one) is registered
// in the result register as the pixel leaves the input stage (stage A), where
// it waits while the registered read port of the line memory returns the two
// rows above. A result is produced only for interior pixels: the transaction
// for pixel (r, c) with r >= 2 and c >= 2 yields the mean of the window
// centred on (r-1, c-1), with that centre's row/column and a frame_last flag
// on the last interior pixel of the frame. Border pixels yield nothing.
// Geometry comes from image_width (addr 0x0, clamped to 3..2048) and
// image_height (addr 0x4, clamped to at least 3); change them only while the
// block is idle. The line memory needs no clearing pass after reset: with a
// fixed geometry every entry that feeds a result is written before it is read.
module box_filter_3x3_rgb_top (
  input  wire                         clk,
  input  wire                         rst,
  // APB configuration port
  input  wire                         psel,
  input  wire                         penable,
  input  wire                         pwrite,
  input  wire  [boxf_pkg::PADDR_W-1:0] paddr,
  input  wire  [boxf_pkg::PDATA_W-1:0] pwdata,
  output logic [boxf_pkg::PDATA_W-1:0] prdata,
  output logic                        pready,
  // pixel input channel
  input  wire                         pix_valid,
  output logic                        pix_ready,
  input  wire  [boxf_pkg::CHAN_W-1:0] red,
  input  wire  [boxf_pkg::CHAN_W-1:0] green,
  input  wire  [boxf_pkg::CHAN_W-1:0] blue,
  // result channel
  output logic                        res_valid,
  input  wire                         res_ready,
  output logic [boxf_pkg::CHAN_W-1:0] mean_red,
  output logic [boxf_pkg::CHAN_W-1:0] mean_green,
  output logic [boxf_pkg::CHAN_W-1:0] mean_blue,
  output logic [boxf_pkg::ROW_W-1:0]  center_row,
  output logic [boxf_pkg::COL_W-1:0]  center_col,
  output logic                        frame_last
);
  import boxf_pkg::*;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [DIM_W-1:0] image_width;
  logic [DIM_W-1:0] image_height;
  logic             cfg_wr;
  reg_idx_t         cfg_sel;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_sel = reg_idx_t'(paddr[2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= DIM_W'(640);
      image_height <= DIM_W'(480);
    end else if (cfg_wr) begin
      unique case (cfg_sel)
        REG_IMAGE_WIDTH:  image_width  <= pwdata[DIM_W-1:0];
        REG_IMAGE_HEIGHT: image_height <= pwdata[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_sel)
      REG_IMAGE_WIDTH:  prdata = PDATA_W'(image_width);
      REG_IMAGE_HEIGHT: prdata = PDATA_W'(image_height);
      default:          prdata = '0;
    endcase
  end

  // Effective geometry (clamped)
  logic [DIM_W-1:0] w_eff;
  logic [DIM_W-1:0] h_eff;

  always_comb begin
    if (image_width < DIM_W'(MIN_DIM))        w_eff = DIM_W'(MIN_DIM);
    else if (image_width > DIM_W'(MAX_WIDTH)) w_eff = DIM_W'(MAX_WIDTH);
    else                                      w_eff = image_width;
    if (image_height < DIM_W'(MIN_DIM))       h_eff = DIM_W'(MIN_DIM);
    else if (image_height > DIM_W'(MAX_HEIGHT)) h_eff = DIM_W'(MAX_HEIGHT);
    else                                      h_eff = image_height;
  end

  // ---------------------------------------------------------------------------
  // Raster counters, advanced on each input transaction
  // ---------------------------------------------------------------------------
  logic [COL_W-1:0] col_count, col_count_next;
  logic [ROW_W-1:0] row_count, row_count_next;
  logic             pix_fire;
  logic             col_wrap;
  logic [ROW_W:0]   row_tmp;
  logic [COL_W-1:0] c_cur;
  logic [ROW_W-1:0] r_cur;
  logic             emit_cur;
  logic             last_cur;

  assign pix_fire = pix_valid && pix_ready;

  always_comb begin
    // a counter past the current geometry wraps before use
    col_wrap = DIM_W'(col_count) >= w_eff;
    row_tmp  = col_wrap ? ((ROW_W+1)'(row_count) + 1'b1) : (ROW_W+1)'(row_count);
    c_cur    = col_wrap ? '0 : col_count;
    r_cur    = (row_tmp >= (ROW_W+1)'(h_eff)) ? '0 : row_tmp[ROW_W-1:0];

    emit_cur = (r_cur >= ROW_W'(2)) && (c_cur >= COL_W'(2));
    last_cur = (r_cur == ROW_W'(h_eff - 1'b1)) && (DIM_W'(c_cur) == w_eff - 1'b1);

    if (DIM_W'(c_cur) >= w_eff - 1'b1) begin
      col_count_next = '0;
      row_count_next = (r_cur >= ROW_W'(h_eff - 1'b1)) ? '0 : r_cur + 1'b1;
    end else begin
      col_count_next = c_cur + 1'b1;
      row_count_next = r_cur;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col_count <= '0;
      row_count <= '0;
    end else if (pix_fire) begin
      col_count <= col_count_next;
      row_count <= row_count_next;
    end
  end

  // ---------------------------------------------------------------------------
  // Line memory: {two rows above, one row above} per column. Read on the
  // input transaction, written back when the item leaves stage A. The same
  // column comes round again no sooner than three pixels later.
  // ---------------------------------------------------------------------------
  logic [2*PIX_W-1:0] line_mem [MAX_WIDTH];
  logic [2*PIX_W-1:0] line_q;

  // Stage A (input register)
  logic             a_valid;
  logic             a_fire;
  pixel_t           a_px;
  logic [COL_W-1:0] a_idx;
  logic             a_emit;
  logic             a_last;
  logic [ROW_W-1:0] a_row;
  logic [COL_W-1:0] a_col;

  pixel_t up1;
  pixel_t up2;
  assign up1 = line_q[PIX_W-1:0];
  assign up2 = line_q[2*PIX_W-1:PIX_W];

  assign a_fire    = a_valid && (!a_emit || !res_valid || res_ready);
  assign pix_ready = !a_valid || a_fire;

  always_ff @(posedge clk) begin
    if (pix_fire) begin
      line_q <= line_mem[c_cur];
    end
    if (a_fire) begin
      line_mem[a_idx] <= {up1, a_px};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (pix_fire) begin
      a_valid <= 1'b1;
    end else if (a_fire) begin
      a_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pix_fire) begin
      a_px   <= {red, green, blue};
      a_idx  <= c_cur;
      a_emit <= emit_cur;
      a_last <= last_cur;
      a_row  <= r_cur - 1'b1;
      a_col  <= c_cur - 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // 3x3 window: win[0..2] = column c-2 (rows r-2, r-1, r), win[3..5] = c-1
  // ---------------------------------------------------------------------------
  pixel_t win [6];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 6; i++) begin
        win[i] <= '0;
      end
    end else if (a_fire) begin
      win[0] <= win[3];
      win[1] <= win[4];
      win[2] <= win[5];
      win[3] <= up2;
      win[4] <= up1;
      win[5] <= a_px;
    end
  end

  // Per-channel nine-sample sum and divide by nine
  logic [CHAN_W-1:0] mean_cur [3];

  always_comb begin
    logic [SUM_W-1:0] sum;
    for (int k = 0; k < 3; k++) begin
      sum = SUM_W'(up2[(2-k)*CHAN_W +: CHAN_W]) + SUM_W'(up1[(2-k)*CHAN_W +: CHAN_W])
          + SUM_W'(a_px[(2-k)*CHAN_W +: CHAN_W]);
      for (int s = 0; s < 6; s++) begin
        sum = sum + SUM_W'(win[s][(2-k)*CHAN_W +: CHAN_W]);
      end
      mean_cur[k] = div_nine(sum);
    end
  end

  // ---------------------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (a_fire && a_emit) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (a_fire && a_emit) begin
      mean_red   <= mean_cur[0];
      mean_green <= mean_cur[1];
      mean_blue  <= mean_cur[2];
      center_row <= a_row;
      center_col <= a_col;
      frame_last <= a_last;
    end
  end

endmodule

`default_nettype wire

// ===== sv/box_filter_3x3_rgb_checker.sv =====
// Port-level checker for box_filter_3x3_rgb_top, attached by the bind below.
// Depends on boxf_pkg.
`default_nettype none

module box_filter_3x3_rgb_checker (
  input wire                         clk,
  input wire                         rst,
  input wire                         pix_ready,
  input wire                         res_valid,
  input wire                         res_ready,
  input wire [boxf_pkg::CHAN_W-1:0]  mean_red,
  input wire [boxf_pkg::CHAN_W-1:0]  mean_green,
  input wire [boxf_pkg::CHAN_W-1:0]  mean_blue,
  input wire [boxf_pkg::ROW_W-1:0]   center_row,
  input wire [boxf_pkg::COL_W-1:0]   center_col,
  input wire                         frame_last
);
  import boxf_pkg::*;

  // stalled result holds
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(mean_red) && $stable(mean_green)
      && $stable(mean_blue) && $stable(center_row) && $stable(center_col)
      && $stable(frame_last))
    else $error("result changed while stalled");

  // reset empties the result register
  a_reset_empty: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result valid right after reset");

  // input only back-pressures when the result side is stalled
  a_ready_stall: assert property (@(posedge clk) disable iff (rst)
    !pix_ready |-> res_valid && !res_ready)
    else $error("input stalled without output stall");

  // results never carry a centre in row 0 or column 0
  a_interior: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> center_row != '0 && center_col != '0)
    else $error("result for a border pixel");

endmodule

bind box_filter_3x3_rgb_top box_filter_3x3_rgb_checker u_checker (
  .clk        (clk),
  .rst        (rst),
  .pix_ready  (pix_ready),
  .res_valid  (res_valid),
  .res_ready  (res_ready),
  .mean_red   (mean_red),
  .mean_green (mean_green),
  .mean_blue  (mean_blue),
  .center_row (center_row),
  .center_col (center_col),
  .frame_last (frame_last)
);

`default_nettype wire
